/* src/gb5_pkg.sv */
package gb5_pkg;

  // pixel and line store
  localparam int PIXEL_W     = 8;
  localparam int LINES       = 4;
  localparam int LINE_WORD_W = LINES * PIXEL_W;

  // window geometry
  localparam int KDIM    = 5;
  localparam int WIN_LAG = KDIM - 1;
  localparam int MIN_DIM = 5;

  // configuration registers
  localparam int IMG_WIDTH_W  = 12;
  localparam int IMG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IDX_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IDX_HEIGHT = 2'd1;

  localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // result fields
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 11;

  // sums: a column sum peaks at 16 * 255, a window sum at 256 * 255
  localparam int COL_SUM_W = 12;
  localparam int WIN_SUM_W = 16;

  typedef logic [PIXEL_W-1:0]     pixel_t;
  typedef logic [LINE_WORD_W-1:0] line_word_t;
  typedef logic [COL_SUM_W-1:0]   col_sum_t;
  typedef logic [WIN_SUM_W-1:0]   win_sum_t;
  typedef logic [OUT_ROW_W-1:0]   out_row_t;
  typedef logic [OUT_COL_W-1:0]   out_col_t;

  // per-word tag from the scan counters
  typedef struct packed {
    logic     emit;
    logic     frame_last;
    out_row_t out_row;
    out_col_t out_col;
  } tag_t;

  // binomial 1-4-6-4-1 weighting of five taps
  function automatic win_sum_t kern5(input win_sum_t a, input win_sum_t b, input win_sum_t c,
                                     input win_sum_t d, input win_sum_t e);
    win_sum_t acc;
    acc = a + e + (b << 2) + (d << 2) + (c << 2) + (c << 1);
    return acc;
  endfunction

endpackage

/* src/gb5_stream_if.sv */
// pixel channel
interface gb5_pixel_if;
  logic             valid;
  logic             ready;
  gb5_pkg::pixel_t  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// filtered result channel
interface gb5_result_if;
  logic              valid;
  logic              ready;
  gb5_pkg::pixel_t   filtered;
  gb5_pkg::out_row_t out_row;
  gb5_pkg::out_col_t out_col;
  logic              frame_last;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input filtered, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

/* src/gaussian_blur_5x5_stream.sv */
// 5x5 binomial blur (outer product of 1-4-6-4-1, divided by 256) over 8-bit grayscale
// pixels in raster order. One pixel word is taken per clock cycle unless stalled; an
// accepted word passes through the line store read, then the column sum, then the
// window sum into the output register, and all stages stall together while a result
// waits. One
// result is given for each window lying fully inside the frame, tagged with the row
// and column of its top-left pixel; the last four rows and columns start no window.
// The four previous lines live in one memory of MAX_WIDTH words of 32 bits, read as a
// word is accepted and written back at that column from stage one. The memory has no
// clearing pass: after reset or a register write, the first four rows of a frame only
// refill it and produce no results. Writing either size register restarts the frame.
module gaussian_blur_5x5_stream #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gb5_pixel_if.sink                      in_ch,
  gb5_result_if.source                   out_ch,
  input  logic                           cfg_we,
  input  gb5_pkg::cfg_idx_t              cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                adv, accept;
  logic [CW-1:0]       scan_col;
  gb5_pkg::tag_t       scan_tag;
  gb5_pkg::line_word_t rd_data, wr_data;
  logic                wr_en;

  logic                s1_valid_r;
  gb5_pkg::pixel_t     s1_px_r;
  logic [CW-1:0]       s1_col_r;
  gb5_pkg::tag_t       s1_tag_r;

  logic                s2_valid;
  gb5_pkg::tag_t       s2_tag;
  gb5_pkg::pixel_t     s2_filtered;

  logic                out_valid_r;
  gb5_pkg::pixel_t     out_filtered_r;
  gb5_pkg::out_row_t   out_row_r;
  gb5_pkg::out_col_t   out_col_r;
  logic                out_last_r;

  // whole pipeline moves when the output register is free
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  gb5_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col_addr  (scan_col),
    .tag       (scan_tag)
  );

  // line store: lines shift up by one at the column, new pixel goes on top
  assign wr_en   = adv && s1_valid_r;
  assign wr_data = {s1_px_r, rd_data[gb5_pkg::LINE_WORD_W-1:gb5_pkg::PIXEL_W]};

  gb5_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (scan_col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  // stage one: word waits for its line store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_ch.pixel;
      s1_col_r <= scan_col;
      s1_tag_r <= scan_tag;
    end
  end

  gb5_filter u_filter (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .s1_valid    (s1_valid_r),
    .px          (s1_px_r),
    .lines       (rd_data),
    .s1_tag      (s1_tag_r),
    .s2_valid    (s2_valid),
    .s2_tag      (s2_tag),
    .s2_filtered (s2_filtered)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      out_filtered_r <= s2_filtered;
      out_row_r      <= s2_tag.out_row;
      out_col_r      <= s2_tag.out_col;
      out_last_r     <= s2_tag.frame_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.filtered   = out_filtered_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.frame_last = out_last_r;

  // back-to-back words never read and write the same column in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && accept) |-> (s1_col_r != scan_col))
    else $error("line store read and write hit the same column");

  // a stall freezes stage one so the pending line store data stays matched
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r) && $stable(s1_col_r) && $stable(rd_data))
    else $error("stage one moved during a stall");

endmodule

/* src/gb5_line_mem.sv */
module gb5_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output gb5_pkg::line_word_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  gb5_pkg::line_word_t wr_data
);

  gb5_pkg::line_word_t line_mem_r [DEPTH];
  gb5_pkg::line_word_t rd_data_r;

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/gb5_scan.sv */
module gb5_scan #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  gb5_pkg::cfg_idx_t                    cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 accept,
  output logic [CW-1:0]                        col_addr,
  output gb5_pkg::tag_t                        tag
);

  localparam int WCW = (CW + 1 > gb5_pkg::IMG_WIDTH_W)  ? CW + 1 : gb5_pkg::IMG_WIDTH_W;
  localparam int HCW = (RW + 1 > gb5_pkg::IMG_HEIGHT_W) ? RW + 1 : gb5_pkg::IMG_HEIGHT_W;

  logic [gb5_pkg::IMG_WIDTH_W-1:0]  width_r;
  logic [gb5_pkg::IMG_HEIGHT_W-1:0] height_r;
  logic [CW-1:0]                    col_r, col_nxt;
  logic [RW-1:0]                    row_r, row_nxt;
  logic [WCW-1:0]                   width_ext, w_eff;
  logic [HCW-1:0]                   height_ext, h_eff;
  logic                             last_col, last_row, cfg_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gb5_pkg::WIDTH_RESET;
      height_r <= gb5_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gb5_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_data[gb5_pkg::IMG_WIDTH_W-1:0];
        gb5_pkg::CFG_IDX_HEIGHT: height_r <= cfg_data[gb5_pkg::IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == gb5_pkg::CFG_IDX_WIDTH ||
                              cfg_index == gb5_pkg::CFG_IDX_HEIGHT);

  // effective frame size, saturated into the supported range
  assign width_ext  = WCW'(width_r);
  assign height_ext = HCW'(height_r);

  always_comb begin
    if (width_ext < WCW'(gb5_pkg::MIN_DIM)) begin
      w_eff = WCW'(gb5_pkg::MIN_DIM);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
  end

  always_comb begin
    if (height_ext < HCW'(gb5_pkg::MIN_DIM)) begin
      h_eff = HCW'(gb5_pkg::MIN_DIM);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = height_ext;
    end
  end

  assign last_col = (WCW'(col_r) + WCW'(1)) >= w_eff;
  assign last_row = (HCW'(row_r) + HCW'(1)) >= h_eff;

  // raster position of the next word
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // tag for the word at the current position
  assign col_addr       = col_r;
  assign tag.emit       = (row_r >= RW'(gb5_pkg::WIN_LAG)) && (col_r >= CW'(gb5_pkg::WIN_LAG));
  assign tag.frame_last = last_col && last_row;
  assign tag.out_row    = gb5_pkg::OUT_ROW_W'(row_r - RW'(gb5_pkg::WIN_LAG));
  assign tag.out_col    = gb5_pkg::OUT_COL_W'(col_r - CW'(gb5_pkg::WIN_LAG));

  // a register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0) && (row_r == '0))
    else $error("frame position not cleared by register write");

  // the last word of a frame always closes a full window
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    tag.frame_last |-> tag.emit)
    else $error("frame end flagged outside a full window");

endmodule

/* src/gb5_filter.sv */
module gb5_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                s1_valid,
  input  gb5_pkg::pixel_t     px,
  input  gb5_pkg::line_word_t lines,
  input  gb5_pkg::tag_t       s1_tag,
  output logic                s2_valid,
  output gb5_pkg::tag_t       s2_tag,
  output gb5_pkg::pixel_t     s2_filtered
);

  gb5_pkg::col_sum_t csum_r [gb5_pkg::KDIM];
  gb5_pkg::col_sum_t vsum;
  gb5_pkg::win_sum_t vsum_full, hsum;
  gb5_pkg::tag_t     s2_tag_r;
  logic              s2_valid_r;

  // vertical 1-4-6-4-1 over the four stored lines and the new pixel
  assign vsum_full = gb5_pkg::kern5(
    gb5_pkg::WIN_SUM_W'(lines[0*gb5_pkg::PIXEL_W +: gb5_pkg::PIXEL_W]),
    gb5_pkg::WIN_SUM_W'(lines[1*gb5_pkg::PIXEL_W +: gb5_pkg::PIXEL_W]),
    gb5_pkg::WIN_SUM_W'(lines[2*gb5_pkg::PIXEL_W +: gb5_pkg::PIXEL_W]),
    gb5_pkg::WIN_SUM_W'(lines[3*gb5_pkg::PIXEL_W +: gb5_pkg::PIXEL_W]),
    gb5_pkg::WIN_SUM_W'(px));
  assign vsum = vsum_full[gb5_pkg::COL_SUM_W-1:0];

  // window held as five column sums, newest on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gb5_pkg::KDIM; i++) begin
        csum_r[i] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int i = 0; i < gb5_pkg::KDIM - 1; i++) begin
        csum_r[i] <= csum_r[i + 1];
      end
      csum_r[gb5_pkg::KDIM-1] <= vsum;
    end
  end

  // stage two control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid && s1_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_tag_r <= s1_tag;
    end
  end

  // horizontal 1-4-6-4-1 over the column sums
  assign hsum = gb5_pkg::kern5(
    gb5_pkg::WIN_SUM_W'(csum_r[0]), gb5_pkg::WIN_SUM_W'(csum_r[1]),
    gb5_pkg::WIN_SUM_W'(csum_r[2]), gb5_pkg::WIN_SUM_W'(csum_r[3]),
    gb5_pkg::WIN_SUM_W'(csum_r[4]));

  assign s2_valid    = s2_valid_r;
  assign s2_tag      = s2_tag_r;
  assign s2_filtered = hsum[gb5_pkg::WIN_SUM_W-1 -: gb5_pkg::PIXEL_W];

endmodule

/* dv/tb_gaussian_blur_5x5_stream.sv */
`timescale 1ns / 100ps

module tb_gaussian_blur_5x5_stream;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 4096;
  // pipeline is three deep, leave a margin for words that give no result
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT = 5000;
  localparam int REPORT_CAP = 200;
  localparam int RANDOM_ITEMS = 800;
  // every word at worst behind the longest input gap plus the longest output stall, plus
  // the idle waits around register writes, taken several times over
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam gb5_pkg::cfg_idx_t IDX_SPARE_2 = 2'd2;
  localparam gb5_pkg::cfg_idx_t IDX_SPARE_3 = 2'd3;
  localparam int unsigned BINOM [gb5_pkg::KDIM] = '{1, 4, 6, 4, 1};

  typedef struct packed {
    gb5_pkg::pixel_t   filtered;
    gb5_pkg::out_row_t out_row;
    gb5_pkg::out_col_t out_col;
    logic              frame_last;
  } blurred_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  gb5_pkg::cfg_idx_t              cfg_index = gb5_pkg::CFG_IDX_WIDTH;
  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gb5_pixel_if  pix_ch ();
  gb5_result_if res_ch ();

  gaussian_blur_5x5_stream #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // blur predictor state
  gb5_pkg::pixel_t                  line_hist [gb5_pkg::LINES][MAX_W];
  gb5_pkg::pixel_t                  win_px [gb5_pkg::KDIM][gb5_pkg::KDIM];
  int unsigned                      scan_col = 0;
  int unsigned                      scan_row = 0;
  logic [gb5_pkg::IMG_WIDTH_W-1:0]  width_set = gb5_pkg::WIDTH_RESET;
  logic [gb5_pkg::IMG_HEIGHT_W-1:0] height_set = gb5_pkg::HEIGHT_RESET;

  gb5_pkg::pixel_t pixels_pending [$];
  blurred_t        blurred_due [$];
  int              mismatches = 0;
  logic            pix_taken = 1'b0;
  int unsigned     gap_left = 0;
  int unsigned     calm_in = 0;
  int unsigned     stall_left = 0;
  int unsigned     calm_out = 0;
  int unsigned     cycles = 0;

  function automatic int unsigned eff_width();
    if (width_set < gb5_pkg::MIN_DIM) return gb5_pkg::MIN_DIM;
    if (width_set > MAX_W) return MAX_W;
    return 32'(width_set);
  endfunction

  function automatic int unsigned eff_height();
    if (height_set < gb5_pkg::MIN_DIM) return gb5_pkg::MIN_DIM;
    if (height_set > MAX_H) return MAX_H;
    return 32'(height_set);
  endfunction

  // one pixel through line history and window, queue the blurred word if the window is inside
  function automatic void blur_step(input gb5_pkg::pixel_t px);
    gb5_pkg::pixel_t col_px [gb5_pkg::KDIM];
    int unsigned     acc;
    logic            end_col;
    logic            end_row;
    blurred_t        res;
    for (int k = 0; k < gb5_pkg::LINES; k++) col_px[k] = line_hist[k][scan_col];
    col_px[gb5_pkg::LINES] = px;
    for (int k = 0; k < gb5_pkg::LINES; k++) line_hist[k][scan_col] = col_px[k + 1];
    for (int k = 0; k < gb5_pkg::KDIM; k++) begin
      for (int m = 0; m < gb5_pkg::KDIM - 1; m++) win_px[k][m] = win_px[k][m + 1];
      win_px[k][gb5_pkg::KDIM-1] = col_px[k];
    end
    end_col = (scan_col + 1 >= eff_width());
    end_row = (scan_row + 1 >= eff_height());
    if (scan_row >= gb5_pkg::WIN_LAG && scan_col >= gb5_pkg::WIN_LAG) begin
      acc = 0;
      for (int k = 0; k < gb5_pkg::KDIM; k++)
        for (int m = 0; m < gb5_pkg::KDIM; m++) acc += BINOM[k] * BINOM[m] * win_px[k][m];
      res.filtered   = gb5_pkg::pixel_t'(acc >> 8);
      res.out_row    = gb5_pkg::out_row_t'(scan_row - gb5_pkg::WIN_LAG);
      res.out_col    = gb5_pkg::out_col_t'(scan_col - gb5_pkg::WIN_LAG);
      res.frame_last = end_col && end_row;
      blurred_due.push_back(res);
    end
    if (end_col) begin
      scan_col = 0;
      scan_row = end_row ? 0 : scan_row + 1;
    end else begin
      scan_col = scan_col + 1;
    end
  endfunction

  // size writes restart the frame, spare indexes do nothing
  function automatic void apply_reg(input gb5_pkg::cfg_idx_t idx,
                                    input logic [gb5_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      gb5_pkg::CFG_IDX_WIDTH: width_set = data[gb5_pkg::IMG_WIDTH_W-1:0];
      gb5_pkg::CFG_IDX_HEIGHT: height_set = data[gb5_pkg::IMG_HEIGHT_W-1:0];
      default: return;
    endcase
    scan_col = 0;
    scan_row = 0;
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic gb5_pkg::pixel_t pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return gb5_pkg::pixel_t'($urandom_range(0, 255));
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        pix_ch.valid <= 1'b0;
      end else if (pixels_pending.size() != 0) begin
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= pixels_pending.pop_front();
        if (calm_in != 0) calm_in = calm_in - 1;
        else if ($urandom_range(0, 99) < 3) calm_in = $urandom_range(20, 200);
        else gap_left = pick_idle();
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // accepted pixel words feed the predictor
  always @(posedge clk) begin
    pix_taken <= rst_n && pix_ch.valid && pix_ch.ready;
    if (rst_n && pix_ch.valid && pix_ch.ready) blur_step(pix_ch.pixel);
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (calm_out != 0) calm_out = calm_out - 1;
      else if ($urandom_range(0, 99) < 3) calm_out = $urandom_range(20, 200);
      else stall_left = pick_idle();
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : result_check
    blurred_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (blurred_due.size() == 0) begin
        if (mismatches < REPORT_CAP)
          $display("%0t: unexpected word, expected none, actual filtered %0d row %0d col %0d",
                   $time, res_ch.filtered, res_ch.out_row, res_ch.out_col);
        mismatches++;
      end else begin
        want = blurred_due.pop_front();
        check_field("filtered", 16'(want.filtered), 16'(res_ch.filtered));
        check_field("out_row", 16'(want.out_row), 16'(res_ch.out_row));
        check_field("out_col", 16'(want.out_col), 16'(res_ch.out_col));
        check_field("frame_last", 16'(want.frame_last), 16'(res_ch.frame_last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, blurred_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // block idle: every word taken, every result seen, pipeline flushed
  task automatic wait_idle();
    while (pixels_pending.size() != 0 || pix_ch.valid || blurred_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input gb5_pkg::cfg_idx_t idx,
                           input logic [gb5_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // the spare top bit of a width write must be dropped
  task automatic write_width(input int unsigned w);
    logic [gb5_pkg::CFG_DATA_W-1:0] wdata;
    wdata = gb5_pkg::CFG_DATA_W'(w[gb5_pkg::IMG_WIDTH_W-1:0]);
    wdata[gb5_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    write_reg(gb5_pkg::CFG_IDX_WIDTH, wdata);
  endtask

  task automatic write_size(input int unsigned w, input int unsigned h);
    if ($urandom_range(0, 1) != 0) begin
      write_width(w);
      write_reg(gb5_pkg::CFG_IDX_HEIGHT, h[gb5_pkg::IMG_HEIGHT_W-1:0]);
    end else begin
      write_reg(gb5_pkg::CFG_IDX_HEIGHT, h[gb5_pkg::IMG_HEIGHT_W-1:0]);
      write_width(w);
    end
  endtask

  task automatic queue_pixels(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) pixels_pending.push_back(pick_pixel());
  endtask

  initial begin : stimulus
    int unsigned                    w;
    int unsigned                    h;
    int unsigned                    r;
    int unsigned                    frames;
    int unsigned                    npx;
    int unsigned                    cut;
    int unsigned                    rand_items;
    logic [gb5_pkg::CFG_DATA_W-1:0] spare_data;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    for (int k = 0; k < gb5_pkg::KDIM; k++)
      for (int m = 0; m < gb5_pkg::KDIM; m++) win_px[k][m] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sizes from reset: part of the first row, no window yet
    queue_pixels(20);

    // directed: one smallest frame at full scale
    write_size(gb5_pkg::MIN_DIM, gb5_pkg::MIN_DIM);
    repeat (gb5_pkg::MIN_DIM * gb5_pkg::MIN_DIM) pixels_pending.push_back('1);

    // sizes below range saturate up to the minimum
    write_size(0, 0);
    queue_pixels(gb5_pkg::MIN_DIM * gb5_pkg::MIN_DIM);

    // all-ones width saturates to the widest line, start of a frame
    write_size(12'hFFF, gb5_pkg::MIN_DIM);
    queue_pixels(64);

    // all-ones height saturates upwards, no frame end after a few rows
    write_size(gb5_pkg::MIN_DIM, 13'h1FFF);
    queue_pixels(gb5_pkg::MIN_DIM * 12);

    // random frames, mostly small
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) w = $urandom_range(0, 4);
      else if (r < 80) w = $urandom_range(5, 12);
      else w = $urandom_range(13, 40);
      h = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 9);
      r = $urandom_range(0, 99);
      if (r < 20) write_width(w);
      else if (r < 40) write_reg(gb5_pkg::CFG_IDX_HEIGHT, h[gb5_pkg::IMG_HEIGHT_W-1:0]);
      else write_size(w, h);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        npx = eff_width() * eff_height();
        // a cut-short frame, the next write or frame picks up from there
        if ($urandom_range(0, 99) < 15) npx = $urandom_range(1, npx - 1);
        if ($urandom_range(0, 99) < 10) begin
          cut = $urandom_range(0, npx);
          queue_pixels(cut);
          spare_data = gb5_pkg::CFG_DATA_W'($urandom);
          write_reg(($urandom_range(0, 1) != 0) ? IDX_SPARE_2 : IDX_SPARE_3, spare_data);
          queue_pixels(npx - cut);
        end else begin
          queue_pixels(npx);
        end
        rand_items += npx;
      end
    end

    // drain
    while (pixels_pending.size() != 0 || pix_ch.valid) @(posedge clk);
    for (int i = 0; i < END_WAIT && blurred_due.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (blurred_due.size() != 0) begin
      $display("%0t: %0d expected words never arrived, first row %0d col %0d", $time,
               blurred_due.size(), blurred_due[0].out_row, blurred_due[0].out_col);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/gb5_pkg.sv
src/gb5_stream_if.sv
src/gb5_line_mem.sv
src/gb5_scan.sv
src/gb5_filter.sv
src/gaussian_blur_5x5_stream.sv
dv/tb_gaussian_blur_5x5_stream.sv
